// ===== rtl/weighted_link_table_macros.svh =====
// ----------------------------------------------------------------------------
// weighted link table assertion macros
// shorthand for clocked implication checks, reset masked
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_LINK_TABLE_MACROS_SVH
`define WEIGHTED_LINK_TABLE_MACROS_SVH

// same-cycle implication
`define WLT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WLT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wlt_pkg.sv =====
// ----------------------------------------------------------------------------
// wlt_pkg
// opcodes and fixed constants of the weighted link table
// ----------------------------------------------------------------------------
package wlt_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_SET    = 3'd3,
        OP_ADD    = 3'd4,
        OP_CHANGE = 3'd5,
        OP_FIND   = 3'd6,
        OP_CLEAR  = 3'd7
    } wlt_op_t;

    // head weight after reset, 50.0 in q8.8
    localparam int HEAD_WEIGHT_RESET = 12800;

endpackage

// ===== rtl/wlt_channels.sv =====
// ----------------------------------------------------------------------------
// wlt channels
// request and response channels of the weighted link table
// ----------------------------------------------------------------------------
interface wlt_req_if
    import wlt_pkg::*;
#(
    parameter int ID_WIDTH     = 16,
    parameter int WEIGHT_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    wlt_op_t                        opcode;
    logic [ID_WIDTH-1:0]            link_id;
    logic signed [WEIGHT_WIDTH-1:0] operand_value;

    modport source (output valid, opcode, link_id, operand_value, input ready);
    modport sink   (input valid, opcode, link_id, operand_value, output ready);
endinterface

interface wlt_rsp_if
#(
    parameter int WEIGHT_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [WEIGHT_WIDTH-1:0] weight_out;
    logic                           found;
    logic                           table_full;
    logic                           removed;

    modport source (output valid, weight_out, found, table_full, removed, input ready);
    modport sink   (input valid, weight_out, found, table_full, removed, output ready);
endinterface

// ===== rtl/wlt_ram.sv =====
// ----------------------------------------------------------------------------
// wlt_ram
// entry store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module wlt_ram
#(
    parameter int DEPTH = 64,
    parameter int DW    = 32,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DW-1:0]     wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DW-1:0]     rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== rtl/wlt_wcalc.sv =====
// ----------------------------------------------------------------------------
// wlt_wcalc
// saturating weight add and the sign-crossing clamp of a change
// ----------------------------------------------------------------------------
module wlt_wcalc
#(
    parameter int W_W = 16
)
(
    input  logic signed [W_W-1:0] prev_weight,
    input  logic signed [W_W-1:0] operand,
    output logic signed [W_W-1:0] sum_sat,
    output logic signed [W_W-1:0] change_out
);

    logic signed [W_W:0] sum;
    logic                old_neg;
    logic                old_zero;
    logic                new_neg;
    logic                new_zero;
    logic                clamp;

    assign sum = {prev_weight[W_W-1], prev_weight} + {operand[W_W-1], operand};

    always_comb
    begin
        if (sum[W_W] != sum[W_W-1])
        begin
            sum_sat = sum[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum[W_W-1:0];
        end
    end

    assign old_neg  = prev_weight[W_W-1];
    assign old_zero = (prev_weight == '0);
    assign new_neg  = sum_sat[W_W-1];
    assign new_zero = (sum_sat == '0);

    // clamp on a sign crossing or on reaching zero
    assign clamp      = (!new_neg && (old_neg || old_zero)) || ((new_neg || new_zero) && !old_neg);
    assign change_out = clamp ? '0 : sum_sat;

endmodule

// ===== rtl/wlt_seq.sv =====
// ----------------------------------------------------------------------------
// wlt_seq
// sequencer: decode, linear scan, read-modify-write and compaction
// ----------------------------------------------------------------------------
`include "weighted_link_table_macros.svh"

module wlt_seq
    import wlt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int ID_W  = 16,
    parameter int W_W   = 16,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1),
    localparam int DW     = ID_W + W_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    wlt_req_if.sink               req,
    wlt_rsp_if.source             rsp,
    output logic                  ram_we,
    output logic [ADDR_W-1:0]     ram_waddr,
    output logic [DW-1:0]         ram_wdata,
    output logic [ADDR_W-1:0]     ram_raddr,
    input  logic [DW-1:0]         ram_rdata,
    output logic signed [W_W-1:0] calc_old,
    output logic signed [W_W-1:0] calc_operand,
    input  logic signed [W_W-1:0] calc_add,
    input  logic signed [W_W-1:0] calc_chg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_MODIFY,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    localparam logic signed [W_W-1:0] HEAD_INIT =
        (W_W >= 15) ? W_W'(HEAD_WEIGHT_RESET) : {1'b0, {(W_W-1){1'b1}}};

    state_t                state_reg, state_next;
    wlt_op_t               op_reg, op_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic signed [W_W-1:0] operand_reg, operand_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic signed [W_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [ADDR_W-1:0]     chk_addr_reg, chk_addr_next;
    logic [ADDR_W-1:0]     slot_reg, slot_next;
    logic signed [W_W-1:0] wgt_reg, wgt_next;
    logic                  scan_head_reg, scan_head_next;
    logic signed [W_W-1:0] res_weight_reg, res_weight_next;
    logic                  res_found_reg, res_found_next;
    logic                  res_full_reg, res_full_next;
    logic                  res_removed_reg, res_removed_next;
    logic                  out_vld_reg, out_vld_next;
    logic signed [W_W-1:0] out_weight_reg, out_weight_next;
    logic                  out_found_reg, out_found_next;
    logic                  out_full_reg, out_full_next;
    logic                  out_removed_reg, out_removed_next;

    logic issue;
    logic hit;
    logic id_zero;

    assign issue   = (ptr_reg < count_reg);
    assign hit     = chk_vld_reg && (ram_rdata[DW-1 -: ID_W] == id_reg);
    assign id_zero = (id_reg == '0);

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_vld_reg;
    assign rsp.weight_out = out_weight_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.table_full = out_full_reg;
    assign rsp.removed    = out_removed_reg;

    assign ram_raddr    = ptr_reg[ADDR_W-1:0];
    assign calc_old     = (state_reg == ST_MODIFY) ? wgt_reg : head_reg;
    assign calc_operand = operand_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        id_next          = id_reg;
        operand_next     = operand_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        ptr_next         = ptr_reg;
        chk_vld_next     = chk_vld_reg;
        chk_addr_next    = chk_addr_reg;
        slot_next        = slot_reg;
        wgt_next         = wgt_reg;
        scan_head_next   = scan_head_reg;
        res_weight_next  = res_weight_reg;
        res_found_next   = res_found_reg;
        res_full_next    = res_full_reg;
        res_removed_next = res_removed_reg;
        out_vld_next     = out_vld_reg;
        out_weight_next  = out_weight_reg;
        out_found_next   = out_found_reg;
        out_full_next    = out_full_reg;
        out_removed_next = out_removed_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;

        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.opcode;
                    id_next      = req.link_id;
                    operand_next = req.operand_value;
                    state_next   = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                res_weight_next  = '0;
                res_found_next   = 1'b0;
                res_full_next    = 1'b0;
                res_removed_next = 1'b0;
                ptr_next         = '0;
                chk_vld_next     = 1'b0;
                scan_head_next   = 1'b0;
                state_next       = ST_FINISH;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (count_reg < CNT_W'(DEPTH))
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[ADDR_W-1:0];
                            ram_wdata  = {id_reg, {W_W{1'b0}}};
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            res_full_next = 1'b1;
                        end
                    end
                    OP_CLEAR:
                    begin
                        res_removed_next = (count_reg != '0);
                        count_next       = '0;
                    end
                    OP_DELETE:
                    begin
                        state_next = ST_SCAN;
                    end
                    OP_GET, OP_FIND:
                    begin
                        if (id_zero)
                        begin
                            res_found_next  = 1'b1;
                            res_weight_next = head_reg;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    OP_SET:
                    begin
                        if (id_zero)
                        begin
                            res_found_next  = 1'b1;
                            head_next       = operand_reg;
                            res_weight_next = operand_reg;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    OP_ADD:
                    begin
                        if (id_zero)
                        begin
                            res_found_next  = 1'b1;
                            head_next       = calc_add;
                            res_weight_next = calc_add;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    OP_CHANGE:
                    begin
                        if (id_zero)
                        begin
                            res_found_next  = 1'b1;
                            head_next       = calc_chg;
                            res_weight_next = calc_chg;
                            // head stays, first stored id zero goes
                            if (calc_chg == '0)
                            begin
                                scan_head_next = 1'b1;
                                state_next     = ST_SCAN;
                            end
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                endcase
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    slot_next    = chk_addr_reg;
                    wgt_next     = ram_rdata[W_W-1:0];
                    chk_vld_next = 1'b0;
                    state_next   = ST_MODIFY;
                end
                else if (issue)
                begin
                    ptr_next      = ptr_reg + 1'b1;
                    chk_vld_next  = 1'b1;
                    chk_addr_next = ptr_reg[ADDR_W-1:0];
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    state_next   = ST_FINISH;
                end
            end

            ST_MODIFY:
            begin
                ptr_next     = CNT_W'(slot_reg) + 1'b1;
                chk_vld_next = 1'b0;
                state_next   = ST_FINISH;
                if (scan_head_reg)
                begin
                    res_removed_next = 1'b1;
                    state_next       = ST_SHIFT;
                end
                else
                begin
                    unique case (op_reg)
                        OP_DELETE:
                        begin
                            res_found_next   = 1'b1;
                            res_removed_next = 1'b1;
                            state_next       = ST_SHIFT;
                        end
                        OP_GET, OP_FIND:
                        begin
                            res_found_next  = 1'b1;
                            res_weight_next = wgt_reg;
                        end
                        OP_SET:
                        begin
                            res_found_next  = 1'b1;
                            res_weight_next = operand_reg;
                            ram_we          = 1'b1;
                            ram_waddr       = slot_reg;
                            ram_wdata       = {id_reg, operand_reg};
                        end
                        OP_ADD:
                        begin
                            res_found_next  = 1'b1;
                            res_weight_next = calc_add;
                            ram_we          = 1'b1;
                            ram_waddr       = slot_reg;
                            ram_wdata       = {id_reg, calc_add};
                        end
                        OP_CHANGE:
                        begin
                            res_found_next = 1'b1;
                            if (calc_chg == '0)
                            begin
                                res_removed_next = 1'b1;
                                state_next       = ST_SHIFT;
                            end
                            else
                            begin
                                res_weight_next = calc_chg;
                                ram_we          = 1'b1;
                                ram_waddr       = slot_reg;
                                ram_wdata       = {id_reg, calc_chg};
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SHIFT:
            begin
                // move each later entry down by one slot
                if (chk_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = chk_addr_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (issue)
                begin
                    ptr_next      = ptr_reg + 1'b1;
                    chk_vld_next  = 1'b1;
                    chk_addr_next = ptr_reg[ADDR_W-1:0];
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    if (!chk_vld_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next     = 1'b1;
                    out_weight_next  = res_weight_reg;
                    out_found_next   = res_found_reg;
                    out_full_next    = res_full_reg;
                    out_removed_next = res_removed_reg;
                    state_next       = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_INSERT;
            id_reg          <= '0;
            operand_reg     <= '0;
            count_reg       <= '0;
            head_reg        <= HEAD_INIT;
            ptr_reg         <= '0;
            chk_vld_reg     <= 1'b0;
            chk_addr_reg    <= '0;
            slot_reg        <= '0;
            wgt_reg         <= '0;
            scan_head_reg   <= 1'b0;
            res_weight_reg  <= '0;
            res_found_reg   <= 1'b0;
            res_full_reg    <= 1'b0;
            res_removed_reg <= 1'b0;
            out_vld_reg     <= 1'b0;
            out_weight_reg  <= '0;
            out_found_reg   <= 1'b0;
            out_full_reg    <= 1'b0;
            out_removed_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            id_reg          <= id_next;
            operand_reg     <= operand_next;
            count_reg       <= count_next;
            head_reg        <= head_next;
            ptr_reg         <= ptr_next;
            chk_vld_reg     <= chk_vld_next;
            chk_addr_reg    <= chk_addr_next;
            slot_reg        <= slot_next;
            wgt_reg         <= wgt_next;
            scan_head_reg   <= scan_head_next;
            res_weight_reg  <= res_weight_next;
            res_found_reg   <= res_found_next;
            res_full_reg    <= res_full_next;
            res_removed_reg <= res_removed_next;
            out_vld_reg     <= out_vld_next;
            out_weight_reg  <= out_weight_next;
            out_found_reg   <= out_found_next;
            out_full_reg    <= out_full_next;
            out_removed_reg <= out_removed_next;
        end
    end

    `WLT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "entry count past depth")
    `WLT_ASSERT_NXT(a_accept_decode, req.valid && req.ready, state_reg == ST_DECODE, "transfer not decoded")
    `WLT_ASSERT_NXT(a_insert_count, state_reg == ST_DECODE && op_reg == OP_INSERT && count_reg < CNT_W'(DEPTH), count_reg == $past(count_reg) + 1'b1, "insert did not grow table")
    `WLT_ASSERT_NXT(a_shift_count, state_reg == ST_SHIFT && !issue && !chk_vld_reg, count_reg == $past(count_reg) - 1'b1, "removal did not shrink table")
    `WLT_ASSERT_IMP(a_full_on_insert, state_reg == ST_FINISH && res_full_reg, op_reg == OP_INSERT, "full flag on non-insert")

endmodule

// ===== rtl/weighted_link_table.sv =====
// ----------------------------------------------------------------------------
// weighted_link_table
// ordered (id, weight) link table behind a fixed head entry
//
//   channel  dir  transfer when       payload
//   req      in   valid and ready     opcode, link_id, operand_value
//   rsp      out  valid and ready     weight_out, found, table_full, removed
//
// one item at a time; the single read port of the entry store sets the pace
// insert, clear and head operations: decode, then finish, with no scan
// lookups: a linear scan of up to n stored entries (one entry read per cycle)
// removal, also a head change to zero: scan plus compaction
// reset: empty table, head weight 50.0; the store needs no clearing pass
// a waiting result does not block the next request transfer
// ----------------------------------------------------------------------------
module weighted_link_table
    import wlt_pkg::*;
#(
    parameter int TABLE_DEPTH  = 64,
    parameter int ID_WIDTH     = 16,
    parameter int WEIGHT_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    wlt_req_if.sink    req,
    wlt_rsp_if.source  rsp
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int DW     = ID_WIDTH + WEIGHT_WIDTH;

    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_waddr;
    logic [DW-1:0]                  ram_wdata;
    logic [ADDR_W-1:0]              ram_raddr;
    logic [DW-1:0]                  ram_rdata;
    logic signed [WEIGHT_WIDTH-1:0] calc_old;
    logic signed [WEIGHT_WIDTH-1:0] calc_operand;
    logic signed [WEIGHT_WIDTH-1:0] calc_add;
    logic signed [WEIGHT_WIDTH-1:0] calc_chg;

    wlt_ram #(
        .DEPTH (TABLE_DEPTH),
        .DW    (DW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wlt_wcalc #(
        .W_W (WEIGHT_WIDTH)
    ) u_wcalc (
        .prev_weight (calc_old),
        .operand     (calc_operand),
        .sum_sat     (calc_add),
        .change_out  (calc_chg)
    );

    wlt_seq #(
        .DEPTH (TABLE_DEPTH),
        .ID_W  (ID_WIDTH),
        .W_W   (WEIGHT_WIDTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .calc_old     (calc_old),
        .calc_operand (calc_operand),
        .calc_add     (calc_add),
        .calc_chg     (calc_chg)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the weighted link table.
// A short table of opening transfers covers reset state, weight extremes,
// every opcode, stored id zero, sign crossings and clearing. After it comes a
// long random run that alternates fill, mixed and drain phases, so that the
// table regularly fills up and refuses inserts. Results are checked field
// by field against listed values, or else a local model of the table. Both
// channels idle at random; responses are held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import wlt_pkg::*;

    localparam int DEPTH         = 64;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int SQUEEZE_AT    = 400;
    localparam int SQUEEZE_LEN   = 400;
    localparam int DRAIN_CYCLES  = 150;
    localparam int W_MAX         = 32767;
    localparam int W_MIN         = -32768;
    localparam int HEAD_SLOT     = -1;
    localparam int NO_SLOT       = -2;

    typedef struct packed {
        logic signed [15:0] weight;
        logic               found;
        logic               table_full;
        logic               removed;
    } link_res_t;

    typedef struct packed {
        wlt_op_t            op;
        logic [15:0]        link_id;
        logic signed [15:0] operand;
        logic               typed;
        link_res_t          res;
    } link_step_t;

    localparam link_step_t OPENING_STEPS [26] = '{
        '{OP_GET,    16'h0000, 16'sh0000, 1'b1, '{16'sd12800, 1'b1, 1'b0, 1'b0}},
        '{OP_FIND,   16'h0005, 16'sh0000, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
        '{OP_DELETE, 16'h0000, 16'sh0000, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
        '{OP_CLEAR,  16'h0000, 16'sh0000, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0005, 16'sh1234, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'hFFFF, 16'sh7FFF, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0005, 16'sh8000, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0000, 16'sh0000, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
        '{OP_SET,    16'h0005, 16'sh7FFF, 1'b1, '{16'sh7FFF,  1'b1, 1'b0, 1'b0}},
        '{OP_ADD,    16'h0005, 16'sh0001, 1'b1, '{16'sh7FFF,  1'b1, 1'b0, 1'b0}},
        '{OP_SET,    16'hFFFF, 16'sh8000, 1'b1, '{16'sh8000,  1'b1, 1'b0, 1'b0}},
        '{OP_ADD,    16'hFFFF, 16'shFFFF, 1'b1, '{16'sh8000,  1'b1, 1'b0, 1'b0}},
        '{OP_CHANGE, 16'hFFFF, 16'sh7FFF, 1'b0, '0},
        '{OP_CHANGE, 16'hFFFF, 16'sh0001, 1'b0, '0},
        '{OP_CHANGE, 16'h0005, 16'shFFFF, 1'b0, '0},
        '{OP_CHANGE, 16'h0005, 16'sh8000, 1'b0, '0},
        '{OP_GET,    16'h0005, 16'sh0000, 1'b0, '0},
        '{OP_FIND,   16'h0000, 16'sh0000, 1'b1, '{16'sd12800, 1'b1, 1'b0, 1'b0}},
        '{OP_CHANGE, 16'h0000, 16'shCE00, 1'b0, '0},
        '{OP_CHANGE, 16'h0000, 16'sh0064, 1'b0, '0},
        '{OP_SET,    16'h0000, 16'sh8000, 1'b1, '{16'sh8000,  1'b1, 1'b0, 1'b0}},
        '{OP_ADD,    16'h0000, 16'sh7FFF, 1'b0, '0},
        '{OP_DELETE, 16'h0005, 16'sh0000, 1'b0, '0},
        '{OP_DELETE, 16'h0005, 16'sh0000, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'hA5A5, 16'sh0000, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b0}},
        '{OP_CLEAR,  16'h0000, 16'sh0000, 1'b1, '{16'sd0,     1'b0, 1'b0, 1'b1}}
    };

    // cumulative opcode weights per phase: fill, mixed, drain; the rest is clear
    localparam int OP_MIX [3][7] = '{
        '{50, 55, 63, 73, 83, 93, 100},
        '{20, 32, 42, 55, 68, 85, 97},
        '{8,  40, 50, 58, 66, 80, 98}
    };

    localparam logic [15:0] ID_POOL [8] = '{
        16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h00FF, 16'h8000, 16'hFFFF, 16'h5A5A
    };

    localparam logic signed [15:0] EDGE_WEIGHTS [5] = '{
        16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF, 16'sh0000
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    wlt_req_if #(.ID_WIDTH(16), .WEIGHT_WIDTH(16)) req_ch ();
    wlt_rsp_if #(.WEIGHT_WIDTH(16))                rsp_ch ();

    weighted_link_table #(
        .TABLE_DEPTH  (DEPTH),
        .ID_WIDTH     (16),
        .WEIGHT_WIDTH (16)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [15:0] link_ids [DEPTH];
    int          link_wts [DEPTH];
    int          link_count = 0;
    int          head_wt    = HEAD_WEIGHT_RESET;
    link_res_t   pending_results [$];
    int          error_count  = 0;
    int          results_seen = 0;

    function automatic int clamp_weight(int v);
        if (v > W_MAX)
        begin
            return W_MAX;
        end
        if (v < W_MIN)
        begin
            return W_MIN;
        end
        return v;
    endfunction

    function automatic logic drop_first_link(logic [15:0] id);
        for (int i = 0; i < link_count; i++)
        begin
            if (link_ids[i] == id)
            begin
                for (int j = i; j + 1 < link_count; j++)
                begin
                    link_ids[j] = link_ids[j + 1];
                    link_wts[j] = link_wts[j + 1];
                end
                link_count--;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic link_res_t apply_link_op(wlt_op_t op, logic [15:0] id,
                                                logic signed [15:0] operand);
        link_res_t r;
        int        slot;
        int        old_w;
        int        new_w;
        r = '0;
        case (op)
            OP_INSERT:
            begin
                if (link_count < DEPTH)
                begin
                    link_ids[link_count] = id;
                    link_wts[link_count] = 0;
                    link_count++;
                end
                else
                begin
                    r.table_full = 1'b1;
                end
            end
            OP_DELETE:
            begin
                r.removed = drop_first_link(id);
                r.found   = r.removed;
            end
            OP_CLEAR:
            begin
                r.removed  = (link_count > 0);
                link_count = 0;
            end
            default:
            begin
                slot = NO_SLOT;
                if (id == 16'h0000)
                begin
                    slot = HEAD_SLOT;
                end
                else
                begin
                    for (int i = 0; i < link_count && slot == NO_SLOT; i++)
                    begin
                        if (link_ids[i] == id)
                        begin
                            slot = i;
                        end
                    end
                end
                if (slot != NO_SLOT)
                begin
                    r.found = 1'b1;
                    old_w   = (slot == HEAD_SLOT) ? head_wt : link_wts[slot];
                    new_w   = old_w;
                    case (op)
                        OP_SET:    new_w = int'(operand);
                        OP_ADD:    new_w = clamp_weight(old_w + int'(operand));
                        OP_CHANGE:
                        begin
                            new_w = clamp_weight(old_w + int'(operand));
                            if (new_w >= 0 && old_w <= 0)
                            begin
                                new_w = 0;
                            end
                            if (new_w <= 0 && old_w >= 0)
                            begin
                                new_w = 0;
                            end
                        end
                        default:   new_w = old_w;
                    endcase
                    if (slot == HEAD_SLOT)
                    begin
                        head_wt = new_w;
                    end
                    else
                    begin
                        link_wts[slot] = new_w;
                    end
                    if (op == OP_CHANGE && new_w == 0)
                    begin
                        r.removed = drop_first_link(id);
                    end
                    r.weight = 16'(new_w);
                end
            end
        endcase
        return r;
    endfunction

    function automatic link_step_t rand_link_step(int idx);
        link_step_t s;
        int         phase;
        int         p;
        int         k;
        s     = '0;
        phase = (idx / 150) % 3;
        p     = $urandom_range(0, 99);
        k     = 0;
        while (k < 7 && p >= OP_MIX[phase][k])
        begin
            k++;
        end
        s.op = wlt_op_t'(k);
        p    = $urandom_range(0, 99);
        if (p < 85)
        begin
            s.link_id = ID_POOL[$urandom_range(0, 7)];
        end
        else
        begin
            s.link_id = 16'($urandom);
        end
        p = $urandom_range(0, 99);
        if (p < 40)
        begin
            s.operand = 16'(int'($urandom_range(0, 1024)) - 512);
        end
        else if (p < 60)
        begin
            s.operand = EDGE_WEIGHTS[$urandom_range(0, 4)];
        end
        else
        begin
            s.operand = 16'($urandom);
        end
        return s;
    endfunction

    task automatic send_link_step(link_step_t s);
        link_res_t predicted;
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= s.op;
        req_ch.link_id       <= s.link_id;
        req_ch.operand_value <= s.operand;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = apply_link_op(s.op, s.link_id, s.operand);
        pending_results.push_back(s.typed ? s.res : predicted);
    endtask

    task automatic idle_sender(bit calm);
        int len;
        if (calm || $urandom_range(0, 3) != 0)
        begin
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        req_ch.valid <= 1'b0;
        repeat (len) @(posedge clk);
    endtask

    initial
    begin
        req_ch.valid         = 1'b0;
        req_ch.opcode        = OP_INSERT;
        req_ch.link_id       = '0;
        req_ch.operand_value = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        foreach (OPENING_STEPS[i])
        begin
            send_link_step(OPENING_STEPS[i]);
            idle_sender(1'b0);
        end
        for (int idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            send_link_step(rand_link_step(idx));
            if (idx == RANDOM_ITEMS / 2)
            begin
                // sender pause until everything outstanding is back
                req_ch.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            else
            begin
                idle_sender(((idx / 200) % 4) == 3);
            end
        end
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial
    begin
        int        stall_left;
        bit        squeezed;
        link_res_t got;
        link_res_t want;
        stall_left   = 0;
        squeezed     = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got = '{rsp_ch.weight_out, rsp_ch.found, rsp_ch.table_full, rsp_ch.removed};
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected transfer, got weight %0d found %0b full %0b removed %0b",
                             $realtime, got.weight, got.found, got.table_full, got.removed);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.weight !== want.weight || got.found !== want.found ||
                        got.table_full !== want.table_full || got.removed !== want.removed)
                    begin
                        $display("%0t: mismatch, expected weight %0d found %0b full %0b removed %0b, got weight %0d found %0b full %0b removed %0b",
                                 $realtime, want.weight, want.found, want.table_full, want.removed,
                                 got.weight, got.found, got.table_full, got.removed);
                        error_count++;
                    end
                end
            end
            if (!squeezed && results_seen == SQUEEZE_AT)
            begin
                // long hold-off so the block backs up onto its input
                squeezed   = 1'b1;
                stall_left = SQUEEZE_LEN;
            end
            else if (stall_left == 0 && ((results_seen / 200) % 4) != 1 &&
                     $urandom_range(0, 7) == 0)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 4);
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
